### src/twu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twu_pkg
// Shared constants, register codes and types of the pixel warp unit.
// ----------------------------------------------------------------------------
package twu_pkg;

    localparam int MESH_DEPTH_DEF = 65536;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int PIX_W   = 12;
    localparam int IDX_W   = 16;
    localparam int TEX_W   = 24;
    localparam int OUT_W   = 15;
    localparam int ADDR_W  = 17;
    localparam int PROD_W  = 29;
    localparam int INV_W   = 17;
    localparam int SIZE_W  = 8;
    localparam int SHIFT_W = 13;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y    = 3'd5;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_MAP   = 1'b1;

    localparam logic [INV_W-1:0]  INV_STEP_X_RST = 17'd4096;
    localparam logic [INV_W-1:0]  INV_STEP_Y_RST = 17'd4729;
    localparam logic [SIZE_W-1:0] COLUMNS_RST    = 8'd64;
    localparam logic [SIZE_W-1:0] ROWS_RST       = 8'd64;

    localparam int OUT_MAX = 16383;
    localparam int OUT_MIN = -16384;

    typedef struct packed {
        logic [INV_W-1:0]          inv_step_x;
        logic [INV_W-1:0]          inv_step_y;
        logic [SIZE_W-1:0]         columns;
        logic [SIZE_W-1:0]         rows;
        logic signed [SHIFT_W-1:0] shift_x;
        logic signed [SHIFT_W-1:0] shift_y;
    } twu_cfg_t;

    typedef struct packed {
        logic                    act;
        logic [IDX_W-1:0]        idx;
        logic signed [TEX_W-1:0] u;
        logic signed [TEX_W-1:0] v;
    } twu_item_t;

endpackage

### src/triangle_mesh_pixel_warp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_mesh_pixel_warp_unit
// Maps screen pixels through a triangle warp mesh held in on-chip memory.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock while no stall backs up to the input. A
// map transaction passes ten register stages before its result is presented on
// the master side. A write transaction returns nothing and updates the mesh at
// the read stage, in order with the maps around it. The mesh is held in three
// identical memory copies so that the three triangle corners are read in the
// same cycle. Stalls on the master side back up stage by stage, and empty stages
// keep accepting input while a result waits. s_tready and cfg_ready stay low
// while reset is held.
module triangle_mesh_pixel_warp_unit #(
    parameter int MESH_DEPTH = twu_pkg::MESH_DEPTH_DEF,
    parameter int FRAC_BITS  = twu_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // mesh_index[15:0], mesh_u[39:16], mesh_v[63:40], pixel_x[75:64], pixel_y[87:76]
    input  logic [87:0]                          s_tdata,
    // action[0]
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // mapped_x[14:0], mapped_y[29:15], zero[31:30]
    output logic [31:0]                          m_tdata,
    // clamped[0]
    output logic                                 m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [twu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [twu_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import twu_pkg::*;

    localparam int RAM_AW = $clog2(MESH_DEPTH);
    localparam int WW     = FRAC_BITS + 3;

    // configuration
    twu_cfg_t cfg_reg;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inv_step_x <= INV_STEP_X_RST;
            cfg_reg.inv_step_y <= INV_STEP_Y_RST;
            cfg_reg.columns    <= COLUMNS_RST;
            cfg_reg.rows       <= ROWS_RST;
            cfg_reg.shift_x    <= '0;
            cfg_reg.shift_y    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_INV_STEP_X: cfg_reg.inv_step_x <= cfg_data;
                REG_INV_STEP_Y: cfg_reg.inv_step_y <= cfg_data;
                REG_COLUMNS:    cfg_reg.columns    <= cfg_data[SIZE_W-1:0];
                REG_ROWS:       cfg_reg.rows       <= cfg_data[SIZE_W-1:0];
                REG_SHIFT_X:    cfg_reg.shift_x    <= cfg_data[SHIFT_W-1:0];
                REG_SHIFT_Y:    cfg_reg.shift_y    <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // front end
    twu_item_t            in_item, loc_item;
    logic                 loc_in_ready;
    logic                 loc_valid, loc_ready, loc_clamped;
    logic signed [WW-1:0] loc_wa, loc_wb;
    logic [ADDR_W-1:0]    loc_pa, loc_pb, loc_pc;

    assign in_item.act = s_tuser;
    assign in_item.idx = s_tdata[15:0];
    assign in_item.u   = s_tdata[39:16];
    assign in_item.v   = s_tdata[63:40];
    assign s_tready    = loc_in_ready && aresetn;

    twu_locate #(.FRAC_BITS(FRAC_BITS)) u_locate (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (loc_in_ready),
        .in_item     (in_item),
        .in_px       (s_tdata[75:64]),
        .in_py       (s_tdata[87:76]),
        .out_valid   (loc_valid),
        .out_ready   (loc_ready),
        .out_item    (loc_item),
        .out_wa      (loc_wa),
        .out_wb      (loc_wb),
        .out_pa      (loc_pa),
        .out_pb      (loc_pb),
        .out_pc      (loc_pc),
        .out_clamped (loc_clamped)
    );

    // mesh read / write stage
    logic                 v6_reg, map6_reg, cl6_reg;
    logic                 oka6_reg, okb6_reg, okc6_reg;
    logic signed [WW-1:0] wa6_reg, wb6_reg;
    logic                 blend_ready, rdy6, adv6, is_map;
    logic                 oka, okb, okc, okw;
    logic [2*TEX_W-1:0]   rda, rdb, rdc, wdata;

    assign rdy6      = !v6_reg || !map6_reg || blend_ready;
    assign loc_ready = rdy6;
    assign adv6      = rdy6 && loc_valid;
    assign is_map    = loc_item.act == ACT_MAP;
    assign oka       = 32'(loc_pa) < 32'(MESH_DEPTH);
    assign okb       = 32'(loc_pb) < 32'(MESH_DEPTH);
    assign okc       = 32'(loc_pc) < 32'(MESH_DEPTH);
    assign okw       = 32'(loc_item.idx) < 32'(MESH_DEPTH);
    assign wdata     = {loc_item.v, loc_item.u};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (rdy6) begin
            v6_reg <= loc_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy6) begin
            map6_reg <= is_map;
            cl6_reg  <= loc_clamped;
            oka6_reg <= oka;
            okb6_reg <= okb;
            okc6_reg <= okc;
            wa6_reg  <= loc_wa;
            wb6_reg  <= loc_wb;
        end
    end

    twu_mesh_ram #(.DEPTH(MESH_DEPTH), .AW(RAM_AW)) u_ram_a (
        .aclk  (aclk),
        .we    (adv6 && !is_map && okw),
        .waddr (RAM_AW'(loc_item.idx)),
        .wdata (wdata),
        .re    (adv6 && is_map && oka),
        .raddr (RAM_AW'(loc_pa)),
        .rdata (rda)
    );

    twu_mesh_ram #(.DEPTH(MESH_DEPTH), .AW(RAM_AW)) u_ram_b (
        .aclk  (aclk),
        .we    (adv6 && !is_map && okw),
        .waddr (RAM_AW'(loc_item.idx)),
        .wdata (wdata),
        .re    (adv6 && is_map && okb),
        .raddr (RAM_AW'(loc_pb)),
        .rdata (rdb)
    );

    twu_mesh_ram #(.DEPTH(MESH_DEPTH), .AW(RAM_AW)) u_ram_c (
        .aclk  (aclk),
        .we    (adv6 && !is_map && okw),
        .waddr (RAM_AW'(loc_item.idx)),
        .wdata (wdata),
        .re    (adv6 && is_map && okc),
        .raddr (RAM_AW'(loc_pc)),
        .rdata (rdc)
    );

    // out-of-store corners read as zero
    logic signed [TEX_W-1:0] au, av, bu, bv, cu, cv;

    assign au = oka6_reg ? rda[TEX_W-1:0]       : '0;
    assign av = oka6_reg ? rda[2*TEX_W-1:TEX_W] : '0;
    assign bu = okb6_reg ? rdb[TEX_W-1:0]       : '0;
    assign bv = okb6_reg ? rdb[2*TEX_W-1:TEX_W] : '0;
    assign cu = okc6_reg ? rdc[TEX_W-1:0]       : '0;
    assign cv = okc6_reg ? rdc[2*TEX_W-1:TEX_W] : '0;

    // back end
    logic signed [OUT_W-1:0] mx, my;

    twu_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (v6_reg && map6_reg),
        .in_ready    (blend_ready),
        .in_au       (au),
        .in_av       (av),
        .in_bu       (bu),
        .in_bv       (bv),
        .in_cu       (cu),
        .in_cv       (cv),
        .in_wa       (wa6_reg),
        .in_wb       (wb6_reg),
        .in_clamped  (cl6_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_x       (mx),
        .out_y       (my),
        .out_clamped (m_tuser)
    );

    assign m_tdata = {2'b00, my, mx};

endmodule

### src/twu_mesh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twu_mesh_ram
// One copy of the mesh point store, one write and one registered read port.
// ----------------------------------------------------------------------------
module twu_mesh_ram #(
    parameter int DEPTH = twu_pkg::MESH_DEPTH_DEF,
    parameter int AW    = $clog2(twu_pkg::MESH_DEPTH_DEF)
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [2*twu_pkg::TEX_W-1:0]  wdata,
    input  logic                         re,
    input  logic [AW-1:0]                raddr,
    output logic [2*twu_pkg::TEX_W-1:0]  rdata
);
    import twu_pkg::*;

    logic [2*TEX_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/twu_locate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twu_locate
// Five-stage front end: pixel scaling, row/cell clamp, triangle choice,
// corner addresses and interpolation weights.
// ----------------------------------------------------------------------------
module twu_locate #(
    parameter int FRAC_BITS = twu_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  twu_pkg::twu_cfg_t               cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  twu_pkg::twu_item_t              in_item,
    input  logic [twu_pkg::PIX_W-1:0]       in_px,
    input  logic [twu_pkg::PIX_W-1:0]       in_py,
    output logic                            out_valid,
    input  logic                            out_ready,
    output twu_pkg::twu_item_t              out_item,
    output logic signed [FRAC_BITS+2:0]     out_wa,
    output logic signed [FRAC_BITS+2:0]     out_wb,
    output logic [twu_pkg::ADDR_W-1:0]      out_pa,
    output logic [twu_pkg::ADDR_W-1:0]      out_pb,
    output logic [twu_pkg::ADDR_W-1:0]      out_pc,
    output logic                            out_clamped
);
    import twu_pkg::*;

    localparam int FW = FRAC_BITS + 1;
    localparam int WW = FRAC_BITS + 3;
    localparam int XW = PROD_W + 1;
    localparam logic [FW-1:0] ONE = FW'(64'd1 << FRAC_BITS);

    logic [SIZE_W-1:0] cc, cc_m1, rr_m1;
    logic [ADDR_W-1:0] cc1, cc2;

    assign cc    = (cfg.columns == '0) ? SIZE_W'(1) : cfg.columns;
    assign cc_m1 = cc - SIZE_W'(1);
    assign rr_m1 = (cfg.rows == '0) ? '0 : cfg.rows - SIZE_W'(1);
    assign cc1   = ADDR_W'(cc) + ADDR_W'(1);
    assign cc2   = ADDR_W'(cc) + ADDR_W'(2);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // stage 1: input register
    twu_item_t          item1_reg;
    logic [PIX_W-1:0]   px1_reg, py1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            item1_reg <= in_item;
            px1_reg   <= in_px;
            py1_reg   <= in_py;
        end
    end

    // stage 2: scale by reciprocal steps
    twu_item_t          item2_reg;
    logic [PROD_W-1:0]  prodx2_reg, prody2_reg;
    logic [PROD_W-1:0]  prodx2_next, prody2_next;

    assign prodx2_next = PROD_W'(px1_reg) * PROD_W'(cfg.inv_step_x);
    assign prody2_next = PROD_W'(py1_reg) * PROD_W'(cfg.inv_step_y);

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            item2_reg  <= item1_reg;
            prodx2_reg <= prodx2_next;
            prody2_reg <= prody2_next;
        end
    end

    // stage 3: row clamp, row offset into x
    twu_item_t          item3_reg;
    logic [PROD_W-1:0]  jraw;
    logic               clampy;
    logic [SIZE_W-1:0]  j3_next, j3_reg;
    logic [FW-1:0]      fy3_next, fy3_reg, h3_next, h3_reg;
    logic [XW-1:0]      fullx3_next, fullx3_reg;
    logic               cl3_reg;

    assign jraw        = prody2_reg >> FRAC_BITS;
    assign clampy      = jraw > PROD_W'(rr_m1);
    assign j3_next     = clampy ? rr_m1 : jraw[SIZE_W-1:0];
    assign fy3_next    = clampy ? ONE : FW'(prody2_reg[FRAC_BITS-1:0]);
    assign h3_next     = j3_next[0] ? ((ONE - fy3_next) >> 1) : (fy3_next >> 1);
    assign fullx3_next = XW'(prodx2_reg) + XW'(h3_next);

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            item3_reg  <= item2_reg;
            j3_reg     <= j3_next;
            fy3_reg    <= fy3_next;
            h3_reg     <= h3_next;
            fullx3_reg <= fullx3_next;
            cl3_reg    <= clampy;
        end
    end

    // stage 4: cell clamp, row base address
    twu_item_t          item4_reg;
    logic [XW-1:0]      iraw;
    logic               clampx;
    logic [SIZE_W-1:0]  i4_next, i4_reg;
    logic [FW-1:0]      fx4_next, fx4_reg, fy4_reg, h4_reg;
    logic [ADDR_W-1:0]  jb4_next, jb4_reg;
    logic               odd4_reg, cl4_reg;

    assign iraw     = fullx3_reg >> FRAC_BITS;
    assign clampx   = iraw > XW'(cc_m1);
    assign i4_next  = clampx ? cc_m1 : iraw[SIZE_W-1:0];
    assign fx4_next = clampx ? ONE : FW'(fullx3_reg[FRAC_BITS-1:0]);
    assign jb4_next = ADDR_W'(j3_reg) * cc1;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            item4_reg <= item3_reg;
            i4_reg    <= i4_next;
            fx4_reg   <= fx4_next;
            fy4_reg   <= fy3_reg;
            h4_reg    <= h3_reg;
            jb4_reg   <= jb4_next;
            odd4_reg  <= j3_reg[0];
            cl4_reg   <= cl3_reg | clampx;
        end
    end

    // stage 5: triangle choice, edge half cells, weights and corners
    logic signed [WW-1:0] fxs, fys, ones, fxc;
    logic                 upper, lower_edge, first, last;
    logic [ADDR_W-1:0]    base;
    logic signed [WW-1:0] wa_next, wb_next;
    logic [ADDR_W-1:0]    pa_next, pb_next, pc_next;

    assign fxs   = WW'(fx4_reg);
    assign fys   = WW'(fy4_reg);
    assign ones  = WW'(ONE);
    assign fxc   = (fxs - WW'(h4_reg)) <<< 1;
    assign first = i4_reg == '0;
    assign last  = i4_reg == cc_m1;
    assign base  = jb4_reg + ADDR_W'(i4_reg);
    assign upper = (fxs + fys) <= ones;
    assign lower_edge = fx4_reg >= fy4_reg;

    always_comb begin
        wa_next = '0;
        wb_next = '0;
        pa_next = base;
        pb_next = base;
        pc_next = base;
        if (odd4_reg) begin
            if (upper) begin
                wa_next = first ? fxc : fxs;
                wb_next = fys;
                pa_next = base;
                pb_next = base + ADDR_W'(1);
                pc_next = base + cc1;
            end else begin
                wa_next = ones - fys;
                wb_next = ones - (last ? fxc : fxs);
                pa_next = base + cc2;
                pb_next = base + ADDR_W'(1);
                pc_next = base + cc1;
            end
        end else begin
            if (lower_edge) begin
                wa_next = ones - (last ? fxc : fxs);
                wb_next = fys;
                pa_next = base + ADDR_W'(1);
                pb_next = base;
                pc_next = base + cc2;
            end else begin
                wa_next = ones - fys;
                wb_next = first ? fxc : fxs;
                pa_next = base + cc1;
                pb_next = base;
                pc_next = base + cc2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            out_item    <= item4_reg;
            out_wa      <= wa_next;
            out_wb      <= wb_next;
            out_pa      <= pa_next;
            out_pb      <= pb_next;
            out_pc      <= pc_next;
            out_clamped <= cl4_reg;
        end
    end

    assign out_valid = v5_reg;

endmodule

### src/twu_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twu_blend
// Four-stage back end: corner differences, weighted products, sum and
// rounding, shift and saturation into the output register.
// ----------------------------------------------------------------------------
module twu_blend #(
    parameter int FRAC_BITS = twu_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  twu_pkg::twu_cfg_t                   cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [twu_pkg::TEX_W-1:0]    in_au,
    input  logic signed [twu_pkg::TEX_W-1:0]    in_av,
    input  logic signed [twu_pkg::TEX_W-1:0]    in_bu,
    input  logic signed [twu_pkg::TEX_W-1:0]    in_bv,
    input  logic signed [twu_pkg::TEX_W-1:0]    in_cu,
    input  logic signed [twu_pkg::TEX_W-1:0]    in_cv,
    input  logic signed [FRAC_BITS+2:0]         in_wa,
    input  logic signed [FRAC_BITS+2:0]         in_wb,
    input  logic                                in_clamped,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [twu_pkg::OUT_W-1:0]    out_x,
    output logic signed [twu_pkg::OUT_W-1:0]    out_y,
    output logic                                out_clamped
);
    import twu_pkg::*;

    localparam int WW  = FRAC_BITS + 3;
    localparam int DW  = TEX_W + 1;
    localparam int PMW = WW + DW;
    localparam int TW  = FRAC_BITS + 30;
    localparam int SH  = FRAC_BITS + 8;
    localparam int RW  = TW - SH;
    localparam int SW  = RW + 1;
    localparam logic signed [TW-1:0] RND = TW'(64'd1 << (SH - 1));

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // stage 1: differences
    logic signed [TEX_W-1:0] au1_reg, av1_reg;
    logic signed [DW-1:0]    dbu1_reg, dcu1_reg, dbv1_reg, dcv1_reg;
    logic signed [WW-1:0]    wa1_reg, wb1_reg;
    logic                    cl1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            au1_reg  <= in_au;
            av1_reg  <= in_av;
            dbu1_reg <= DW'(in_bu) - DW'(in_au);
            dcu1_reg <= DW'(in_cu) - DW'(in_au);
            dbv1_reg <= DW'(in_bv) - DW'(in_av);
            dcv1_reg <= DW'(in_cv) - DW'(in_av);
            wa1_reg  <= in_wa;
            wb1_reg  <= in_wb;
            cl1_reg  <= in_clamped;
        end
    end

    // stage 2: products
    logic signed [TEX_W-1:0] au2_reg, av2_reg;
    logic signed [PMW-1:0]   pbu2_reg, pcu2_reg, pbv2_reg, pcv2_reg;
    logic                    cl2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            au2_reg  <= au1_reg;
            av2_reg  <= av1_reg;
            pbu2_reg <= PMW'(wa1_reg) * PMW'(dbu1_reg);
            pcu2_reg <= PMW'(wb1_reg) * PMW'(dcu1_reg);
            pbv2_reg <= PMW'(wa1_reg) * PMW'(dbv1_reg);
            pcv2_reg <= PMW'(wb1_reg) * PMW'(dcv1_reg);
            cl2_reg  <= cl1_reg;
        end
    end

    // stage 3: sum and round to whole texels
    logic signed [TW-1:0] tu, tv, tur, tvr;
    logic signed [RW-1:0] ru3_reg, rv3_reg;
    logic                 cl3_reg;

    assign tu  = (TW'(au2_reg) <<< FRAC_BITS) + TW'(pbu2_reg) + TW'(pcu2_reg) + RND;
    assign tv  = (TW'(av2_reg) <<< FRAC_BITS) + TW'(pbv2_reg) + TW'(pcv2_reg) + RND;
    assign tur = tu >>> SH;
    assign tvr = tv >>> SH;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            ru3_reg <= RW'(tur);
            rv3_reg <= RW'(tvr);
            cl3_reg <= cl2_reg;
        end
    end

    // stage 4: shift and saturate
    logic signed [SW-1:0] sx, sy;
    logic signed [OUT_W-1:0] x_next, y_next;

    assign sx = SW'(ru3_reg) + SW'(cfg.shift_x);
    assign sy = SW'(rv3_reg) + SW'(cfg.shift_y);

    always_comb begin
        priority if (sx > SW'(OUT_MAX)) x_next = OUT_W'(OUT_MAX);
        else if (sx < SW'(OUT_MIN))     x_next = OUT_W'(OUT_MIN);
        else                            x_next = OUT_W'(sx);
        priority if (sy > SW'(OUT_MAX)) y_next = OUT_W'(OUT_MAX);
        else if (sy < SW'(OUT_MIN))     y_next = OUT_W'(OUT_MIN);
        else                            y_next = OUT_W'(sy);
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            out_x       <= x_next;
            out_y       <= y_next;
            out_clamped <= cl3_reg;
        end
    end

    assign out_valid = v4_reg;

endmodule

### verif/tb_triangle_mesh_pixel_warp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_mesh_pixel_warp_unit
// Self-checking bench for the triangle mesh pixel warp unit.
// A directed table, then random phases under several register settings. Maps
// are mostly preceded by writes of their three corner points, so no unwritten
// mesh point is ever read. Every result is checked against an in-bench model of
// the warp or against the expected values in the directed table, with random
// idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_triangle_mesh_pixel_warp_unit;
    import twu_pkg::*;

    localparam int                   CLK_HALF     = 2;
    localparam int                   RST_CYCLES   = 11;
    localparam int                   DRAIN_CYCLES = 20;
    localparam int                   CYCLE_LIMIT  = 400000;
    localparam int                   ITEM_TARGET  = 850;
    localparam int                   IDLE_PCT     = 34;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd7;
    localparam longint               ONE          = 64'sd1 <<< FRAC_BITS_DEF;

    typedef struct {
        logic                    act;
        logic [IDX_W-1:0]        idx;
        int                      u;
        int                      v;
        logic [PIX_W-1:0]        px;
        logic [PIX_W-1:0]        py;
        bit                      typed;
        logic signed [OUT_W-1:0] ex;
        logic signed [OUT_W-1:0] ey;
        logic                    ec;
    } pix_txn_t;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic                    c;
    } warp_res_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [87:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // model state
    longint    inv_x, inv_y, n_cols, n_rows, sh_x, sh_y;
    int        tex_u [MESH_DEPTH_DEF];
    int        tex_v [MESH_DEPTH_DEF];
    bit        tex_seen [MESH_DEPTH_DEF];
    warp_res_t pending_maps [$];

    int  n_sent;
    int  n_errors;
    int  cycle_cnt;
    bit  idle_on;
    bit  hold_out;

    triangle_mesh_pixel_warp_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_INV_STEP_X: inv_x  = data;
            REG_INV_STEP_Y: inv_y  = data;
            REG_COLUMNS:    n_cols = data[SIZE_W-1:0];
            REG_ROWS:       n_rows = data[SIZE_W-1:0];
            REG_SHIFT_X:    sh_x   = $signed(data[SHIFT_W-1:0]);
            REG_SHIFT_Y:    sh_y   = $signed(data[SHIFT_W-1:0]);
            default: ;
        endcase
    endfunction

    // find the triangle of a pixel: corner points and weights
    function automatic void locate_corners(input logic [PIX_W-1:0] px, py,
                                           output int pa, pb, pc,
                                           output longint wa, wb,
                                           output bit clmp);
        longint cc, rr, full, j, i, fx, fy, base;
        cc   = (n_cols == 0) ? 1 : n_cols;
        rr   = (n_rows == 0) ? 1 : n_rows;
        clmp = 1'b0;
        full = longint'(py) * inv_y;
        j    = full >>> FRAC_BITS_DEF;
        fy   = full & (ONE - 1);
        if (j > rr - 1) begin
            j = rr - 1; fy = ONE; clmp = 1'b1;
        end
        full = longint'(px) * inv_x + (j[0] ? ((ONE - fy) >>> 1) : (fy >>> 1));
        i    = full >>> FRAC_BITS_DEF;
        fx   = full & (ONE - 1);
        if (i > cc - 1) begin
            i = cc - 1; fx = ONE; clmp = 1'b1;
        end
        base = j * (cc + 1) + i;
        if (j[0]) begin
            if (fx + fy <= ONE) begin
                if (i == 0) fx = 2 * (fx - ((ONE - fy) >>> 1));
                pa = base; pb = base + 1; pc = base + cc + 1;
                wa = fx; wb = fy;
            end else begin
                if (i == cc - 1) fx = 2 * (fx - ((ONE - fy) >>> 1));
                pa = base + cc + 2; pb = base + 1; pc = base + cc + 1;
                wa = ONE - fy; wb = ONE - fx;
            end
        end else begin
            if (fx >= fy) begin
                if (i == cc - 1) fx = 2 * (fx - (fy >>> 1));
                pa = base + 1; pb = base; pc = base + cc + 2;
                wa = ONE - fx; wb = fy;
            end else begin
                if (i == 0) fx = 2 * (fx - (fy >>> 1));
                pa = base + cc + 1; pb = base; pc = base + cc + 2;
                wa = ONE - fy; wb = fx;
            end
        end
    endfunction

    function automatic logic signed [OUT_W-1:0] round_to_texel(input longint t, input longint sh);
        longint r;
        r = ((t + (64'sd1 <<< (7 + FRAC_BITS_DEF))) >>> (8 + FRAC_BITS_DEF)) + sh;
        if (r > OUT_MAX) r = OUT_MAX;
        if (r < OUT_MIN) r = OUT_MIN;
        return r[OUT_W-1:0];
    endfunction

    function automatic warp_res_t warp_pixel(input logic [PIX_W-1:0] px, py);
        int        pa, pb, pc;
        longint    wa, wb, tu, tv;
        bit        clmp;
        warp_res_t res;
        locate_corners(px, py, pa, pb, pc, wa, wb, clmp);
        tu = longint'(tex_u[pa]) * ONE + wa * (tex_u[pb] - tex_u[pa])
             + wb * (tex_u[pc] - tex_u[pa]);
        tv = longint'(tex_v[pa]) * ONE + wa * (tex_v[pb] - tex_v[pa])
             + wb * (tex_v[pc] - tex_v[pa]);
        res.x = round_to_texel(tu, sh_x);
        res.y = round_to_texel(tv, sh_y);
        res.c = clmp;
        return res;
    endfunction

    task automatic send_item(input pix_txn_t t);
        warp_res_t res;
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= t.act;
        s_tdata  <= {t.py, t.px, t.v[TEX_W-1:0], t.u[TEX_W-1:0], t.idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
        if (t.act == ACT_WRITE) begin
            tex_u[t.idx]    = $signed(t.u[TEX_W-1:0]);
            tex_v[t.idx]    = $signed(t.v[TEX_W-1:0]);
            tex_seen[t.idx] = 1'b1;
        end else begin
            if (t.typed) begin
                res.x = t.ex; res.y = t.ey; res.c = t.ec;
            end else begin
                res = warp_pixel(t.px, t.py);
            end
            pending_maps.push_back(res);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_maps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_regs(input longint ix, iy, cols, rws, sx, sy, input bit spare);
        logic [CFG_DATA_W-1:0] vals [7];
        logic [CFG_IDX_W-1:0]  ids [7];
        int                    n;
        ids[0] = REG_INV_STEP_X; vals[0] = ix;
        ids[1] = REG_INV_STEP_Y; vals[1] = iy;
        ids[2] = REG_COLUMNS;    vals[2] = cols;
        ids[3] = REG_ROWS;       vals[3] = rws;
        ids[4] = REG_SHIFT_X;    vals[4] = sx & 64'h1FFF;
        ids[5] = REG_SHIFT_Y;    vals[5] = sy & 64'h1FFF;
        ids[6] = REG_SPARE;      vals[6] = $urandom;
        n = spare ? 7 : 6;
        for (int k = 0; k < n; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= ids[k];
            cfg_data  <= vals[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            set_reg(ids[k], vals[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic int rand_texel();
        if ($urandom_range(3) == 0) return $signed(24'($urandom));
        return int'($urandom_range(102400)) - 51200;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(3))
            0: return $urandom_range(4095);
            1: return $urandom_range(15);
            2: return 4095 - $urandom_range(15);
            default: return $urandom_range(600);
        endcase
    endfunction

    function automatic pix_txn_t mk_write(input int idx, input int u, input int v);
        pix_txn_t t;
        t = '{default: '0};
        t.act = ACT_WRITE; t.idx = idx; t.u = u; t.v = v;
        t.px = $urandom; t.py = $urandom;
        return t;
    endfunction

    function automatic pix_txn_t mk_map(input logic [PIX_W-1:0] px, py);
        pix_txn_t t;
        t = '{default: '0};
        t.act = ACT_MAP; t.px = px; t.py = py;
        t.idx = $urandom; t.u = $urandom; t.v = $urandom;
        return t;
    endfunction

    // mostly: write the missing corners of a pixel, then map it
    task automatic random_burst();
        pix_txn_t         t;
        logic [PIX_W-1:0] px, py;
        int               pa, pb, pc;
        int               pts [3];
        longint           wa, wb;
        bit               clmp;
        int               r;
        r = $urandom_range(99);
        if (r >= 70 && r < 85) begin
            send_item(mk_write($urandom_range(65535), rand_texel(), rand_texel()));
            return;
        end
        px = rand_pixel();
        py = rand_pixel();
        locate_corners(px, py, pa, pb, pc, wa, wb, clmp);
        pts[0] = pa; pts[1] = pb; pts[2] = pc;
        foreach (pts[k]) begin
            if (!tex_seen[pts[k]] || (r < 70 && $urandom_range(4) == 0))
                send_item(mk_write(pts[k], rand_texel(), rand_texel()));
        end
        send_item(mk_map(px, py));
    endtask

    pix_txn_t directed [$];

    initial begin
        pix_txn_t t;
        int       target;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        n_sent    = 0;
        idle_on   = 1'b1;
        inv_x  = INV_STEP_X_RST;
        inv_y  = INV_STEP_Y_RST;
        n_cols = COLUMNS_RST;
        n_rows = ROWS_RST;
        sh_x   = 0;
        sh_y   = 0;
        repeat (RST_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table under reset settings (row stride 65)
        directed.push_back(mk_write(0, 25600, -1792));
        directed.push_back(mk_write(1, 0, 0));
        directed.push_back(mk_write(66, 0, 0));
        t = mk_map(0, 0); t.typed = 1; t.ex = 100; t.ey = -7; t.ec = 0;
        directed.push_back(t);
        directed.push_back(mk_write(0, 8388607, -8388608));
        t = mk_map(0, 0); t.typed = 1; t.ex = OUT_MAX; t.ey = OUT_MIN; t.ec = 0;
        directed.push_back(t);
        directed.push_back(mk_write(63, 1024, 0));
        directed.push_back(mk_write(64, 2560, 0));
        directed.push_back(mk_write(129, 0, 0));
        t = mk_map(4095, 0); t.typed = 1; t.ex = 16; t.ey = 0; t.ec = 1;
        directed.push_back(t);
        directed.push_back(mk_write(65535, -1, 1));
        directed.push_back(mk_write(4224, -8388608, 8388607));
        directed.push_back(mk_write(4159, -300, 77));
        directed.push_back(mk_write(4223, 5000, -5000));
        directed.push_back(mk_map(4095, 4095));
        directed.push_back(mk_write(65, 777, -777));
        directed.push_back(mk_write(130, -128, 128));
        directed.push_back(mk_write(67, 129, -129));
        directed.push_back(mk_map(0, 14));
        directed.push_back(mk_map(7, 14));
        directed.push_back(mk_map(16, 10));
        foreach (directed[k]) send_item(directed[k]);

        for (int ph = 0; ph < 7; ph++) begin
            wait_idle();
            case (ph)
                0: load_regs(65536, 65536, 255, 255, 4095, -4096, 1'b1);
                1: load_regs(0, 0, 1, 1, -4096, 4095, 1'b0);
                2: load_regs(13107, 21845, 5, 3, 17, -33, 1'b0);
                3: load_regs(INV_STEP_X_RST, INV_STEP_Y_RST, 0, 0, -5, 9, 1'b0);
                4: load_regs($urandom_range(200, 5000), $urandom_range(200, 5000),
                             $urandom_range(1, 255), $urandom_range(1, 255),
                             int'($urandom_range(8191)) - 4096,
                             int'($urandom_range(8191)) - 4096, 1'b0);
                5: load_regs($urandom_range(65536), $urandom_range(65536),
                             $urandom_range(1, 20), $urandom_range(1, 20),
                             int'($urandom_range(200)) - 100,
                             int'($urandom_range(200)) - 100, 1'b0);
                default: load_regs(INV_STEP_X_RST, INV_STEP_Y_RST, COLUMNS_RST,
                                   ROWS_RST, 0, 0, 1'b0);
            endcase
            target = 25 + (ph + 1) * ITEM_TARGET / 7;
            while (n_sent < target) begin
                idle_on = !(n_sent >= 380 && n_sent < 500);
                random_burst();
            end
        end

        s_tvalid <= 1'b0;
        while (pending_maps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // long output stall while the input keeps offering
    initial begin
        wait (n_sent >= 200);
        @(posedge aclk);
        hold_out = 1'b1;
        repeat (400) @(posedge aclk);
        hold_out = 1'b0;
    end

    always @(posedge aclk) begin
        warp_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_maps.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    want = pending_maps.pop_front();
                    if ($signed(m_tdata[14:0]) !== want.x)
                        report_mismatch("mapped_x", $signed(m_tdata[14:0]), want.x);
                    if ($signed(m_tdata[29:15]) !== want.y)
                        report_mismatch("mapped_y", $signed(m_tdata[29:15]), want.y);
                    if (m_tuser !== want.c)
                        report_mismatch("clamped", m_tuser, want.c);
                end
            end
            m_tready <= !hold_out && !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

endmodule

### triangle_mesh_pixel_warp_unit.f
src/twu_pkg.sv
src/twu_mesh_ram.sv
src/twu_locate.sv
src/twu_blend.sv
src/triangle_mesh_pixel_warp_unit.sv
verif/tb_triangle_mesh_pixel_warp_unit.sv
